// ===== rtl/core/skt_pkg.sv =====
`timescale 1ns / 1ps
package skt_pkg;
  localparam int CAPACITY   = 256;
  localparam int SAVE_DEPTH = 16;
  localparam int KEY_BITS   = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = IDX_W + 1;
  // signed index: must hold -1 and the full count
  localparam int SIDX_W     = IDX_W + 2;
  localparam int SD_W       = $clog2(SAVE_DEPTH) + 1;
  localparam int SA_W       = (SAVE_DEPTH > 1) ? $clog2(SAVE_DEPTH) : 1;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_FIND    = 3'd1;
  localparam logic [2:0] OP_REMOVE  = 3'd2;
  localparam logic [2:0] OP_SAVE    = 3'd3;
  localparam logic [2:0] OP_RESTORE = 3'd4;

  // compare result codes
  typedef enum logic [1:0] {REL_LT = 2'd0, REL_EQ = 2'd1, REL_GT = 2'd2} rel_t;

  function automatic rel_t key_order(input logic [KEY_BITS-1:0] a,
                                     input logic [KEY_BITS-1:0] b);
    rel_t r;
    if (a < b) r = REL_LT;
    else if (a > b) r = REL_GT;
    else r = REL_EQ;
    return r;
  endfunction
endpackage

// ===== rtl/core/skt_ram.sv =====
`timescale 1ns / 1ps
module skt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/sorted_key_table_with_cursor_unit.sv =====
`timescale 1ns / 1ps
// Rejected ops: dispatch, done; save adds a push, restore a read and a pop. Add/find/remove:
// a read and a compare per key probe (plus a midpoint step to bisect) and per equal key
// walked, a read and a write per entry shifted, then a pass over the saved cursors after a
// shifting add or any remove. Worst case: front add walking back over a full equal run, then
// full shift. One operation at a time; busy from acceptance until done strobes for one cycle.
// Reset (rst, synchronous): table empty, cursor -1, stack empty, sorted_mode 1; no stall.
module sorted_key_table_with_cursor_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    operation,
  input  logic [31:0]                   key,
  input  logic                          at_front,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data,
  output logic                          done,
  output logic                          ok,
  output logic signed [8:0]             position,
  output logic [31:0]                   found_key,
  output logic [8:0]                    entry_count,
  output logic signed [8:0]             cursor
);
  localparam int IW = skt_pkg::IDX_W;
  localparam int SW = skt_pkg::SIDX_W;
  localparam int KB = skt_pkg::KEY_BITS;
  localparam logic signed [SW-1:0] ONE = SW'(1);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_LOCATE, S_RD, S_LIN_CMP, S_SEED_CMP, S_MID, S_MID_CMP,
    S_LO_CMP, S_HI_CMP, S_LOC_DONE, S_WBACK_CMP, S_WFWD_CMP, S_SHIFT_SETUP, S_SHR_RD,
    S_SHR_WR, S_WRITE, S_SHL_RD, S_SHL_WR, S_REM_UPD, S_ADJ, S_FOUND, S_SAVE,
    S_RESTORE_RD, S_RESTORE, S_DONE
  } state_t;

  state_t state, ret;
  logic sorted_mode;
  logic [2:0] op;
  logic [KB-1:0] k;
  logic front;
  logic [skt_pkg::CNT_W-1:0] held;
  logic signed [SW-1:0] cur, last_ins;
  logic uniq;
  logic [skt_pkg::SD_W-1:0] sdepth;
  logic signed [SW-1:0] lo, hi, mid, pos, idx;
  skt_pkg::rel_t rel;
  logic r_ok;
  logic [31:0] r_fkey;
  logic [skt_pkg::SD_W-1:0] adj_i;

  // key store
  logic          kwe;
  logic [IW-1:0] kwaddr, kraddr;
  logic [KB-1:0] kwdata, krdata;
  skt_ram #(.WIDTH(KB), .DEPTH(skt_pkg::CAPACITY)) u_keys (
    .clk(clk), .we(kwe), .waddr(kwaddr), .wdata(kwdata), .raddr(kraddr), .rdata(krdata));

  // saved cursor stack
  logic                     swe;
  logic [skt_pkg::SA_W-1:0] swaddr, sraddr;
  logic signed [SW-1:0]     swdata, srdata;
  skt_ram #(.WIDTH(SW), .DEPTH(skt_pkg::SAVE_DEPTH)) u_stack (
    .clk(clk), .we(swe), .waddr(swaddr), .wdata(swdata), .raddr(sraddr), .rdata(srdata));

  skt_pkg::rel_t cmp;
  assign cmp = skt_pkg::key_order(k, krdata);

  logic signed [SW-1:0] held_s, mid_calc, nlo, nhi, seed;
  logic signed [SW:0]   lohi;
  logic                 seed_ok;
  assign held_s   = SW'(held);
  assign lohi     = {lo[SW-1], lo} + {hi[SW-1], hi};
  assign mid_calc = SW'(lohi >>> 1);
  assign nlo      = (cmp == skt_pkg::REL_LT) ? lo : mid;
  assign nhi      = (cmp == skt_pkg::REL_LT) ? mid : hi;
  assign seed     = (op == skt_pkg::OP_ADD) ? last_ins : cur;
  assign seed_ok  = !seed[SW-1] && (seed < held_s);

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // memory port drive
  always_comb begin
    kraddr = idx[IW-1:0];
    kwe    = 1'b0;
    kwaddr = idx[IW-1:0];
    kwdata = krdata;
    if (state == S_SHR_WR) begin
      kwe = 1'b1;
      kwaddr = IW'(idx + ONE);
    end else if (state == S_SHL_WR) begin
      kwe = 1'b1;
      kwaddr = IW'(idx - ONE);
    end else if (state == S_WRITE) begin
      kwe = 1'b1;
      kwaddr = pos[IW-1:0];
      kwdata = k;
    end
    swe    = 1'b0;
    swaddr = adj_i[skt_pkg::SA_W-1:0];
    swdata = srdata;
    sraddr = adj_i[skt_pkg::SA_W-1:0];
    if (state == S_SAVE) begin
      swe = 1'b1;
      swaddr = sdepth[skt_pkg::SA_W-1:0];
      swdata = cur;
    end else if (state == S_ADJ && adj_i != '0) begin
      // write back the previous entry read last cycle
      swaddr = skt_pkg::SA_W'(adj_i - 1'b1);
      if (op == skt_pkg::OP_ADD && srdata >= pos) begin
        swe = 1'b1; swdata = srdata + ONE;
      end else if (op == skt_pkg::OP_REMOVE && pos <= srdata) begin
        swe = 1'b1; swdata = srdata - ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sorted_mode <= 1'b1;
      held <= '0;
      cur <= '1;
      last_ins <= '1;
      uniq <= 1'b1;
      sdepth <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid) sorted_mode <= cfg_data;
          if (start) begin
            op <= operation;
            k <= KB'(key);
            front <= at_front;
            r_ok <= 1'b0;
            r_fkey <= '0;
            pos <= '1;
            adj_i <= '0;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state <= S_DONE;
          case (op)
            skt_pkg::OP_ADD: begin
              if (k != '0 && held < skt_pkg::CNT_W'(skt_pkg::CAPACITY)) begin
                if (held == '0 || !sorted_mode) begin
                  pos <= front ? '0 : held_s;
                  state <= S_SHIFT_SETUP;
                end else state <= S_LOCATE;
              end
            end
            skt_pkg::OP_FIND, skt_pkg::OP_REMOVE: begin
              if (k != '0 && held != '0) state <= S_LOCATE;
            end
            skt_pkg::OP_SAVE:
              if (sdepth < skt_pkg::SD_W'(skt_pkg::SAVE_DEPTH)) state <= S_SAVE;
            skt_pkg::OP_RESTORE:
              if (sdepth != '0) begin
                adj_i <= sdepth - 1'b1;
                state <= S_RESTORE_RD;
              end
            default: state <= S_DONE;
          endcase
        end
        S_LOCATE: begin
          if (!sorted_mode) begin
            idx <= '0; ret <= S_LIN_CMP; state <= S_RD;
          end else if (seed_ok) begin
            idx <= seed; ret <= S_SEED_CMP; state <= S_RD;
          end else begin
            // stale seed: bisect the whole table
            lo <= '0; hi <= held_s - ONE; state <= S_MID;
          end
        end
        S_RD: state <= ret;
        S_LIN_CMP: begin
          if (cmp == skt_pkg::REL_EQ) begin
            rel <= skt_pkg::REL_EQ; mid <= idx; state <= S_LOC_DONE;
          end else if (idx == held_s - ONE) begin
            rel <= skt_pkg::REL_GT; mid <= held_s; state <= S_LOC_DONE;
          end else begin
            idx <= idx + ONE; state <= S_RD;
          end
        end
        S_SEED_CMP: begin
          rel <= cmp; mid <= idx;
          if (cmp == skt_pkg::REL_EQ || (cmp == skt_pkg::REL_LT && idx == '0) ||
              (cmp == skt_pkg::REL_GT && idx == held_s - ONE))
            state <= S_LOC_DONE;
          else begin
            if (cmp == skt_pkg::REL_LT) begin lo <= '0; hi <= idx; end
            else begin lo <= idx; hi <= held_s - ONE; end
            state <= S_MID;
          end
        end
        S_MID: begin
          idx <= mid_calc;
          mid <= mid_calc;
          ret <= S_MID_CMP;
          state <= S_RD;
        end
        S_MID_CMP: begin
          if (cmp == skt_pkg::REL_EQ) begin
            rel <= skt_pkg::REL_EQ; state <= S_LOC_DONE;
          end else begin
            lo <= nlo; hi <= nhi;
            if (nhi - nlo > ONE) state <= S_MID;
            else begin
              idx <= nlo; ret <= S_LO_CMP; state <= S_RD;
            end
          end
        end
        S_LO_CMP: begin
          if (cmp != skt_pkg::REL_GT) begin
            rel <= cmp; mid <= lo; state <= S_LOC_DONE;
          end else begin
            idx <= hi; ret <= S_HI_CMP; state <= S_RD;
          end
        end
        S_HI_CMP: begin
          rel <= cmp; mid <= hi; state <= S_LOC_DONE;
        end
        S_LOC_DONE: begin
          case (op)
            skt_pkg::OP_ADD: begin
              if (rel == skt_pkg::REL_GT) begin
                pos <= mid + ONE; state <= S_SHIFT_SETUP;
              end else if (rel == skt_pkg::REL_LT) begin
                pos <= mid; state <= S_SHIFT_SETUP;
              end else begin
                uniq <= 1'b0;
                if (front) begin
                  pos <= mid;
                  idx <= mid - ONE;
                  ret <= S_WBACK_CMP;
                  state <= (mid == '0) ? S_SHIFT_SETUP : S_RD;
                end else begin
                  pos <= mid + ONE;
                  idx <= mid + ONE;
                  ret <= S_WFWD_CMP;
                  state <= (mid + ONE < held_s) ? S_RD : S_SHIFT_SETUP;
                end
              end
            end
            skt_pkg::OP_FIND: begin
              if (rel == skt_pkg::REL_EQ) begin
                pos <= mid;
                idx <= mid - ONE;
                ret <= S_WBACK_CMP;
                state <= (!uniq && sorted_mode && mid != '0) ? S_RD : S_FOUND;
              end else begin
                cur <= '1; state <= S_DONE;
              end
            end
            default: begin
              if (rel == skt_pkg::REL_EQ) begin
                pos <= mid;
                held <= held - 1'b1;
                idx <= mid + ONE;
                state <= (mid + ONE < held_s) ? S_SHL_RD : S_REM_UPD;
              end else state <= S_DONE;
            end
          endcase
        end
        // walk back to the first key of an equal run
        S_WBACK_CMP: begin
          if (cmp == skt_pkg::REL_EQ) begin
            pos <= idx;
            idx <= idx - ONE;
            if (idx == '0) state <= (op == skt_pkg::OP_ADD) ? S_SHIFT_SETUP : S_FOUND;
            else state <= S_RD;
          end else state <= (op == skt_pkg::OP_ADD) ? S_SHIFT_SETUP : S_FOUND;
        end
        // walk forward past the end of an equal run
        S_WFWD_CMP: begin
          if (cmp == skt_pkg::REL_EQ) begin
            pos <= idx + ONE;
            idx <= idx + ONE;
            state <= (idx + ONE < held_s) ? S_RD : S_SHIFT_SETUP;
          end else state <= S_SHIFT_SETUP;
        end
        S_SHIFT_SETUP: begin
          if (pos < held_s) begin
            idx <= held_s - ONE; state <= S_SHR_RD;
          end else state <= S_WRITE;
        end
        S_SHR_RD: state <= S_SHR_WR;
        S_SHR_WR: begin
          if (idx == pos) state <= S_WRITE;
          else begin
            idx <= idx - ONE; state <= S_SHR_RD;
          end
        end
        S_WRITE: begin
          held <= held + 1'b1;
          last_ins <= pos;
          if (pos < held_s && cur >= pos) cur <= cur + ONE;
          r_ok <= 1'b1;
          adj_i <= '0;
          state <= (pos < held_s && sdepth != '0) ? S_ADJ : S_DONE;
        end
        S_SHL_RD: state <= S_SHL_WR;
        S_SHL_WR: begin
          // held already holds the new count here
          if (idx == held_s) state <= S_REM_UPD;
          else begin
            idx <= idx + ONE; state <= S_SHL_RD;
          end
        end
        S_REM_UPD: begin
          if (pos <= cur) cur <= cur - ONE;
          if (pos < last_ins) last_ins <= last_ins - ONE;
          else if (pos == last_ins) last_ins <= '1;
          if (held <= skt_pkg::CNT_W'(1)) uniq <= 1'b1;
          r_ok <= 1'b1;
          adj_i <= '0;
          state <= (sdepth != '0) ? S_ADJ : S_DONE;
        end
        S_ADJ: begin
          if (adj_i == sdepth) state <= S_DONE;
          else adj_i <= adj_i + 1'b1;
        end
        S_FOUND: begin
          cur <= pos;
          r_fkey <= 32'(k);
          r_ok <= 1'b1;
          state <= S_DONE;
        end
        S_SAVE: begin
          sdepth <= sdepth + 1'b1;
          r_ok <= 1'b1;
          state <= S_DONE;
        end
        S_RESTORE_RD: state <= S_RESTORE;
        S_RESTORE: begin
          cur <= srdata;
          sdepth <= sdepth - 1'b1;
          r_ok <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          ok <= r_ok;
          position <= (r_ok && op != skt_pkg::OP_SAVE && op != skt_pkg::OP_RESTORE)
                      ? 9'(pos) : '1;
          found_key <= r_fkey;
          entry_count <= 9'(held);
          cursor <= 9'(cur);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/skt_checker.sv =====
`timescale 1ns / 1ps
module skt_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       ok,
  input logic [8:0] position,
  input logic [8:0] entry_count,
  input logic [31:0] found_key
);
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without operation");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");
  a_fail_pos: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (position == 9'h1FF && found_key == '0)) else $error("fail payload");
  a_count: assert property (@(posedge clk) disable iff (rst)
    done |-> entry_count <= 9'd256) else $error("count range");
endmodule

bind sorted_key_table_with_cursor_unit skt_checker u_skt_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .ok(ok),
  .position(position), .entry_count(entry_count), .found_key(found_key));

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int SETTLE      = 900;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] k;
    logic        front;
  } cmd_t;

  typedef struct {
    logic        ok;
    logic [8:0]  pos;
    logic [31:0] fkey;
    logic [8:0]  cnt;
    logic [8:0]  cur;
  } rsp_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [2:0]  operation = '0;
  logic [31:0] key = '0;
  logic        at_front = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_data = 0;
  logic        done;
  logic        ok;
  logic signed [8:0] position;
  logic [31:0] found_key;
  logic [8:0]  entry_count;
  logic signed [8:0] cursor;

  sorted_key_table_with_cursor_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .key(key), .at_front(at_front),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .ok(ok), .position(position), .found_key(found_key),
    .entry_count(entry_count), .cursor(cursor)
  );

  always #10 clk = ~clk;

  cmd_t pend_cmds[$];
  rsp_t want_rsp[$];
  int   err_cnt = 0;
  int   cycles = 0;
  logic took = 0;
  int   gap = 0;

  // table shadow
  logic [31:0] tbl [skt_pkg::CAPACITY];
  int          n_held = 0;
  int          cur_idx = -1;
  int          last_ins = -1;
  bit          uniq = 1;
  int          stack_cur [skt_pkg::SAVE_DEPTH];
  int          stack_n = 0;
  bit          sorted_m = 1;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %0h exp %0h at %0t", what, got, exp, $realtime);
    err_cnt++;
  endtask

  function automatic int cmp_key(input logic [31:0] a, input logic [31:0] b);
    return a < b ? -1 : (a > b ? 1 : 0);
  endfunction

  // closest index to k; rel is k versus that entry
  function automatic int search(input logic [31:0] k, input int seed, output int rel);
    int lo, hi, mid, d;
    mid = 0;
    d = 1;
    if (!sorted_m) begin
      for (int i = 0; i < n_held; i++)
        if (tbl[i] == k) begin
          rel = 0;
          return i;
        end
      rel = 1;
      return n_held;
    end
    if (seed >= 0 && seed < n_held) begin
      d = cmp_key(k, tbl[seed]);
      if (d == 0 || (d < 0 && seed == 0) || (d > 0 && seed == n_held - 1)) begin
        rel = d;
        return seed;
      end
      if (d < 0) begin
        lo = 0;
        hi = seed;
      end else begin
        lo = seed;
        hi = n_held - 1;
      end
    end else begin
      lo = 0;
      hi = n_held - 1;
    end
    do begin
      mid = (lo + hi) / 2;
      d = cmp_key(k, tbl[mid]);
      if (d == 0) break;
      if (d < 0) hi = mid;
      else lo = mid;
    end while (hi - lo > 1);
    if (d != 0) begin
      d = cmp_key(k, tbl[lo]);
      if (d <= 0) mid = lo;
      else begin
        d = cmp_key(k, tbl[hi]);
        mid = hi;
      end
    end
    rel = d;
    return mid;
  endfunction

  task automatic apply_cmd(input cmd_t c, output rsp_t r);
    int p, i, d;
    bit good;
    logic [31:0] fk;
    p = -1;
    good = 0;
    fk = '0;
    case (c.op)
      skt_pkg::OP_ADD: if (c.k != 0 && n_held < skt_pkg::CAPACITY) begin
        if (n_held == 0 || !sorted_m) p = c.front ? 0 : n_held;
        else begin
          p = search(c.k, last_ins, d);
          if (d > 0) p++;
          else if (d == 0) begin
            uniq = 0;
            if (c.front) begin
              while (p > 0 && tbl[p-1] == c.k) p--;
            end else begin
              do p++; while (p < n_held && tbl[p] == c.k);
            end
          end
        end
        if (p < n_held) begin
          for (i = n_held; i > p; i--) tbl[i] = tbl[i-1];
          if (cur_idx >= p) cur_idx++;
          for (i = 0; i < stack_n; i++) if (stack_cur[i] >= p) stack_cur[i]++;
        end
        tbl[p] = c.k;
        n_held++;
        last_ins = p;
        good = 1;
      end
      skt_pkg::OP_FIND: if (c.k != 0 && n_held > 0) begin
        i = search(c.k, cur_idx, d);
        if (d == 0) begin
          if (!uniq && sorted_m) while (i > 0 && tbl[i-1] == c.k) i--;
          cur_idx = i;
          p = i;
          fk = tbl[i];
          good = 1;
        end else cur_idx = -1;
      end
      skt_pkg::OP_REMOVE: if (c.k != 0 && n_held > 0) begin
        i = search(c.k, cur_idx, d);
        if (d == 0) begin
          n_held--;
          for (p = i; p < n_held; p++) tbl[p] = tbl[p+1];
          p = i;
          if (i <= cur_idx) cur_idx--;
          if (i < last_ins) last_ins--;
          else if (i == last_ins) last_ins = -1;
          for (d = 0; d < stack_n; d++) if (i <= stack_cur[d]) stack_cur[d]--;
          if (n_held <= 1) uniq = 1;
          good = 1;
        end
      end
      skt_pkg::OP_SAVE: if (stack_n < skt_pkg::SAVE_DEPTH) begin
        stack_cur[stack_n] = cur_idx;
        stack_n++;
        good = 1;
      end
      skt_pkg::OP_RESTORE: if (stack_n > 0) begin
        stack_n--;
        cur_idx = stack_cur[stack_n];
        good = 1;
      end
      default: ;
    endcase
    r.ok = good;
    r.pos = p[8:0];
    r.fkey = fk;
    r.cnt = n_held[8:0];
    r.cur = cur_idx[8:0];
  endtask

  // accept transfers, predict, check results
  always @(posedge clk) begin
    rsp_t r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else if (!rst) begin
      if (cfg_valid && cfg_ready) sorted_m = cfg_data;
      took <= start && !busy;
      if (start && !busy) begin
        apply_cmd('{operation, key, at_front}, r);
        want_rsp.push_back(r);
      end
      if (done) begin
        if (want_rsp.size() == 0) report("unexpected result", 0, 0);
        else begin
          r = want_rsp.pop_front();
          if (ok !== r.ok) report("ok", ok, r.ok);
          if (position !== r.pos) report("position", position, r.pos);
          if (found_key !== r.fkey) report("found_key", found_key, r.fkey);
          if (entry_count !== r.cnt) report("entry_count", entry_count, r.cnt);
          if (cursor !== r.cur) report("cursor", cursor, r.cur);
        end
      end
    end
  end

  // command driver
  always @(negedge clk) begin
    cmd_t c;
    logic nxt;
    nxt = start;
    if (start && took) nxt = 0;
    if (!rst && !nxt) begin
      if (gap > 0) gap--;
      else if (pend_cmds.size() > 0) begin
        c = pend_cmds.pop_front();
        operation <= c.op;
        key <= c.k;
        at_front <= c.front;
        nxt = 1;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      end
    end
    start <= nxt;
  end

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int w;
    w = $urandom_range(0, 99);
    if (w < 36) c.op = skt_pkg::OP_ADD;
    else if (w < 60) c.op = skt_pkg::OP_FIND;
    else if (w < 84) c.op = skt_pkg::OP_REMOVE;
    else if (w < 91) c.op = skt_pkg::OP_SAVE;
    else if (w < 98) c.op = skt_pkg::OP_RESTORE;
    else c.op = 3'(skt_pkg::OP_RESTORE + $urandom_range(1, 3));
    w = $urandom_range(0, 99);
    if (w < 3) c.k = '0;
    else if (w < 10) c.k = $urandom();
    else if (w < 13) c.k = '1;
    else c.k = $urandom_range(1, 40);
    c.front = $urandom_range(0, 1);
    return c;
  endfunction

  task automatic push_cmd(input logic [2:0] op, input logic [31:0] k, input logic f);
    pend_cmds.push_back('{op, k, f});
  endtask

  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pend_cmds.size() != 0 || start || want_rsp.size() != 0 || busy);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_run(input int n);
    repeat (n) pend_cmds.push_back(rand_cmd());
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // empty table, null key, duplicates, misses, stack edges
    push_cmd(skt_pkg::OP_FIND, 32'd5, 0);
    push_cmd(skt_pkg::OP_REMOVE, 32'd5, 0);
    push_cmd(skt_pkg::OP_RESTORE, 32'd0, 0);
    push_cmd(skt_pkg::OP_ADD, 32'd0, 1);
    push_cmd(skt_pkg::OP_ADD, 32'd5, 0);
    push_cmd(skt_pkg::OP_ADD, 32'd5, 1);
    push_cmd(skt_pkg::OP_ADD, 32'hFFFF_FFFF, 0);
    push_cmd(skt_pkg::OP_ADD, 32'd5, 0);
    push_cmd(skt_pkg::OP_ADD, 32'd1, 1);
    push_cmd(skt_pkg::OP_FIND, 32'd5, 0);
    push_cmd(skt_pkg::OP_SAVE, 32'd0, 0);
    push_cmd(skt_pkg::OP_FIND, 32'd7, 0);
    push_cmd(skt_pkg::OP_FIND, 32'hFFFF_FFFF, 0);
    push_cmd(skt_pkg::OP_RESTORE, 32'd0, 0);
    push_cmd(skt_pkg::OP_FIND, 32'd0, 0);
    push_cmd(3'(skt_pkg::OP_RESTORE + 1), 32'd5, 1);
    push_cmd(3'(skt_pkg::OP_RESTORE + 3), 32'hA5A5_5A5A, 1);
    push_cmd(skt_pkg::OP_REMOVE, 32'd5, 0);
    push_cmd(skt_pkg::OP_REMOVE, 32'd9, 0);
    push_cmd(skt_pkg::OP_REMOVE, 32'd1, 0);
    push_cmd(skt_pkg::OP_REMOVE, 32'd5, 0);
    push_cmd(skt_pkg::OP_REMOVE, 32'd5, 0);
    push_cmd(skt_pkg::OP_FIND, 32'hFFFF_FFFF, 0);
    drain();

    set_mode(0);
    random_run(250);

    // fill to capacity, then overflow and mixed traffic on a full table
    set_mode(1);
    repeat (skt_pkg::CAPACITY + 4)
      push_cmd(skt_pkg::OP_ADD, $urandom_range(1, 90), $urandom_range(0, 1));
    repeat (20) push_cmd(skt_pkg::OP_SAVE, 32'd0, 0);
    random_run(250);

    set_mode(0);
    random_run(150);
    set_mode(1);
    random_run(200);

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
